>>> hw/rtl/trimmed_mean_window_filter_core_macros.svh
// Assertion macros used by the trimmed-mean window filter datapath.
// Each macro expands to one labeled concurrent assertion on the rising clock edge.
`ifndef TRIMMED_MEAN_WINDOW_FILTER_CORE_MACROS_SVH
`define TRIMMED_MEAN_WINDOW_FILTER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TMWF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TMWF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/tmwf_pkg.sv
// Package for the trimmed-mean window filter: beat types, controller states,
// command and status bundles, and default parameter values. No dependencies.
`timescale 1ns / 1ps

package tmwf_pkg;

  localparam int WINDOW_DEF      = 16;
  localparam int TRIM_DEF        = 2;
  localparam int CHANNELS_DEF    = 7;
  localparam int SAMPLE_BITS_DEF = 12;

  localparam int CHANNEL_W       = 3;
  localparam int SAMPLE_W        = 12;
  localparam int TRIMMED_SUM_W   = 16;
  localparam int FILTERED_CODE_W = 12;

  typedef struct packed {
    logic [CHANNEL_W-1:0] channel;
    logic [SAMPLE_W-1:0]  sample;
  } item_t;

  typedef struct packed {
    logic [CHANNEL_W-1:0]       out_channel;
    logic [TRIMMED_SUM_W-1:0]   trimmed_sum;
    logic [FILTERED_CODE_W-1:0] filtered_code;
  } result_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WRITE,
    S_SCAN,
    S_DRAIN,
    S_SUM,
    S_MULT,
    S_DONE
  } tmwf_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;
    logic load;
    logic write;
    logic scan;
    logic sum;
    logic mult;
    logic publish;
  } tmwf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic ch_ok;
    logic scan_last;
    logic result_busy;
  } tmwf_status_t;

endpackage

>>> hw/rtl/tmwf_ctrl.sv
// Controller state machine of the trimmed-mean window filter.
// Depends on tmwf_pkg for the state enum and the command and status bundles.
`timescale 1ns / 1ps

module tmwf_ctrl import tmwf_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  input  tmwf_status_t status,
  output logic         item_stall,
  output tmwf_cmd_t    cmd
);

  tmwf_state_t state;
  tmwf_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (status.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (item_valid) state_next = S_WRITE;
      end
      S_WRITE: begin
        state_next = status.ch_ok ? S_SCAN : S_DONE;
      end
      S_SCAN: begin
        if (status.scan_last) state_next = S_DRAIN;
      end
      S_DRAIN: state_next = S_SUM;
      S_SUM:   state_next = S_MULT;
      S_MULT:  state_next = S_DONE;
      S_DONE: begin
        if (!status.result_busy) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd        = '0;
    item_stall = 1'b1;
    case (state)
      S_CLEAR: cmd.clr_step = 1'b1;
      S_IDLE: begin
        item_stall = 1'b0;
        cmd.load   = item_valid;
      end
      S_WRITE: cmd.write = status.ch_ok;
      S_SCAN:  cmd.scan  = 1'b1;
      S_DRAIN: cmd       = '0;
      S_SUM:   cmd.sum   = 1'b1;
      S_MULT:  cmd.mult  = 1'b1;
      S_DONE:  cmd.publish = !status.result_busy;
      default: cmd = '0;
    endcase
  end

endmodule

>>> hw/rtl/tmwf_dp.sv
// Datapath of the trimmed-mean window filter: window memory, ring pointers, rank
// tracking, trimmed sum, reciprocal divide and result register. Uses tmwf_pkg and the macros.
`timescale 1ns / 1ps
`include "trimmed_mean_window_filter_core_macros.svh"

module tmwf_dp import tmwf_pkg::*; #(
  parameter int WINDOW      = WINDOW_DEF,
  parameter int TRIM        = TRIM_DEF,
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  item_t        item,
  input  tmwf_cmd_t    cmd,
  output tmwf_status_t status,
  input  logic         result_stall,
  output logic         result_valid,
  output result_t      result
);

  localparam int IDX_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ADDR_W    = CH_W + IDX_W;
  localparam int MEM_DEPTH = CHANNELS << IDX_W;
  localparam int SUM_W     = SAMPLE_BITS + $clog2(WINDOW);
  localparam int LIST_N    = (TRIM > 0) ? TRIM : 1;
  localparam int KEPT      = (WINDOW > 2 * TRIM) ? (WINDOW - 2 * TRIM) : 0;
  localparam int KDIV      = (KEPT > 0) ? KEPT : 1;
  localparam int REC_L     = $clog2(KDIV);
  localparam int REC_S     = SUM_W + REC_L;
  localparam int REC_M_W   = SUM_W + 2;
  localparam int PROD_W    = SUM_W + REC_M_W + REC_L;
  localparam int CHK_W     = CHANNEL_W + 2;
  localparam int CMP_W     = (SUM_W > TRIMMED_SUM_W) ? SUM_W : TRIMMED_SUM_W;

  // Multiply-by-reciprocal constant: exact floor division for SUM_W-bit sums.
  localparam logic [REC_M_W-1:0] REC_M =
    REC_M_W'(((64'd1 << REC_S) + 64'(KDIV) - 64'd1) / 64'(KDIV));
  localparam logic [ADDR_W-1:0] CLR_LAST  = ADDR_W'(MEM_DEPTH - 1);
  localparam logic [IDX_W-1:0]  SCAN_LAST = IDX_W'(WINDOW - 1);
  localparam logic [CMP_W-1:0]  SUM_MAX   = CMP_W'({TRIMMED_SUM_W{1'b1}});
  localparam logic [CMP_W-1:0]  CODE_MAX  = CMP_W'({FILTERED_CODE_W{1'b1}});

  logic [SAMPLE_BITS-1:0] mem [MEM_DEPTH];
  logic [SAMPLE_BITS-1:0] mem_q;
  logic [ADDR_W-1:0]      clr_addr;
  logic [IDX_W-1:0]       wpos [CHANNELS];
  logic [CHANNEL_W-1:0]   channel_q;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic [IDX_W-1:0]       scan_idx;
  logic                   rd_pending;
  logic [SUM_W-1:0]       total;
  logic [SAMPLE_BITS-1:0] low  [LIST_N];
  logic [SAMPLE_BITS-1:0] high [LIST_N];
  logic [SAMPLE_BITS-1:0] low_next  [LIST_N];
  logic [SAMPLE_BITS-1:0] high_next [LIST_N];
  logic [LIST_N-1:0]      lt;
  logic [LIST_N-1:0]      gt;
  logic [SUM_W-1:0]       low_sum;
  logic [SUM_W-1:0]       high_sum;
  logic [SUM_W-1:0]       trimmed;
  logic [SUM_W-1:0]       trimmed_next;
  logic [SUM_W-1:0]       quot;
  logic [PROD_W-1:0]      prod;
  logic [CH_W-1:0]        ch_idx;
  logic [IDX_W-1:0]       cur_pos;
  logic                   wr_en;
  logic [ADDR_W-1:0]      wr_addr;
  logic [SAMPLE_BITS-1:0] wr_data;
  logic [CMP_W-1:0]       sum_wide;
  logic [CMP_W-1:0]       quot_wide;

  assign ch_idx  = CH_W'(channel_q);
  assign cur_pos = wpos[ch_idx];

  assign status.ch_ok       = CHK_W'(channel_q) < CHK_W'(CHANNELS);
  assign status.clr_last    = (clr_addr == CLR_LAST);
  assign status.scan_last   = (scan_idx == SCAN_LAST);
  assign status.result_busy = result_valid && result_stall;

  // One write port shared by the clearing pass and the ring write.
  assign wr_en   = cmd.clr_step || cmd.write;
  assign wr_addr = cmd.clr_step ? clr_addr : {ch_idx, cur_pos};
  assign wr_data = cmd.clr_step ? '0 : sample_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.scan) begin
      mem_q <= mem[{ch_idx, scan_idx}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr   <= '0;
      rd_pending <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        wpos[i] <= '0;
      end
    end else begin
      rd_pending <= cmd.scan;
      if (cmd.clr_step) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.write) begin
        wpos[ch_idx] <= (cur_pos == SCAN_LAST) ? '0 : cur_pos + 1'b1;
      end
    end
  end

  // Keep the TRIM lowest values in ascending order and the TRIM highest in
  // descending order; a new value slides in where it belongs.
  always_comb begin
    for (int i = 0; i < LIST_N; i++) begin
      lt[i] = mem_q < low[i];
      gt[i] = mem_q > high[i];
    end
    low_next[0]  = lt[0] ? mem_q : low[0];
    high_next[0] = gt[0] ? mem_q : high[0];
    for (int i = 1; i < LIST_N; i++) begin
      low_next[i]  = !lt[i] ? low[i]  : (lt[i-1] ? low[i-1]  : mem_q);
      high_next[i] = !gt[i] ? high[i] : (gt[i-1] ? high[i-1] : mem_q);
    end
  end

  always_comb begin
    low_sum  = '0;
    high_sum = '0;
    for (int i = 0; i < LIST_N; i++) begin
      low_sum  = low_sum + SUM_W'(low[i]);
      high_sum = high_sum + SUM_W'(high[i]);
    end
    if (KEPT == 0) begin
      trimmed_next = '0;
    end else if (TRIM == 0) begin
      trimmed_next = total;
    end else begin
      trimmed_next = total - low_sum - high_sum;
    end
  end

  assign prod = PROD_W'(trimmed) * PROD_W'(REC_M);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      channel_q <= item.channel;
      sample_q  <= SAMPLE_BITS'(item.sample);
      trimmed   <= '0;
      quot      <= '0;
    end
    if (cmd.write) begin
      scan_idx <= '0;
      total    <= '0;
      for (int i = 0; i < LIST_N; i++) begin
        low[i]  <= '1;
        high[i] <= '0;
      end
    end
    if (cmd.scan) begin
      scan_idx <= scan_idx + 1'b1;
    end
    if (rd_pending) begin
      total <= total + SUM_W'(mem_q);
      low   <= low_next;
      high  <= high_next;
    end
    if (cmd.sum) begin
      trimmed <= trimmed_next;
    end
    if (cmd.mult) begin
      quot <= prod[REC_S +: SUM_W];
    end
  end

  assign sum_wide  = CMP_W'(trimmed);
  assign quot_wide = CMP_W'(quot);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.publish) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      result.out_channel   <= channel_q;
      result.trimmed_sum   <= (sum_wide > SUM_MAX) ? '1 : TRIMMED_SUM_W'(sum_wide);
      result.filtered_code <= (quot_wide > CODE_MAX) ? '1 : FILTERED_CODE_W'(quot_wide);
    end
  end

  `TMWF_ASSERT_NOW(a_bad_channel_zero, clk, rst, result_valid && (int'(result.out_channel) >= CHANNELS), (result.trimmed_sum == '0) && (result.filtered_code == '0), "out-of-range channel gave a nonzero result")
  `TMWF_ASSERT_NOW(a_mean_below_sum, clk, rst, result_valid, TRIMMED_SUM_W'(result.filtered_code) <= result.trimmed_sum, "filtered code exceeds trimmed sum")
  `TMWF_ASSERT_NEXT(a_publish_channel, clk, rst, cmd.publish, result_valid && (result.out_channel == $past(channel_q)), "published beat lost its channel")

endmodule

>>> hw/rtl/trimmed_mean_window_filter_core.sv
// Trimmed-mean window filter: top level joining the controller and the datapath (uses tmwf_pkg).
// A beat on an out-of-range channel skips the walk over its window. A new beat is taken only
// once the last one is through, since the walk over the channel's window goes through the
// single read port of the window memory. Reset is synchronous; afterwards a clearing pass
// zeroes all CHANNELS * 2**clog2(WINDOW) entries of the memory, one entry a cycle, while
// item_stall stays high.
`timescale 1ns / 1ps

module trimmed_mean_window_filter_core import tmwf_pkg::*; #(
  parameter int WINDOW      = WINDOW_DEF,
  parameter int TRIM        = TRIM_DEF,
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  // The controller sequences one beat at a time: write the new sample into the
  // channel's ring, read the whole window back one entry per cycle while the datapath
  // tracks the running total and the lowest and highest TRIM values, then form the
  // trimmed sum, divide it by the kept count through a reciprocal multiply, and load
  // the result register. The result register lets the next beat be taken while a
  // finished result still waits downstream.
  tmwf_cmd_t    cmd;
  tmwf_status_t status;

  tmwf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .status     (status),
    .item_stall (item_stall),
    .cmd        (cmd)
  );

  // The datapath owns all data storage: window memory, ring pointers, rank lists,
  // sums and the output register.
  tmwf_dp #(
    .WINDOW      (WINDOW),
    .TRIM        (TRIM),
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .status       (status),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

>>> tb/tmwf_scoreboard_pkg.sv
// Scoreboard for the trimmed-mean window filter testbench: a per-channel window
// predictor and a queue of expected result beats. Depends on tmwf_pkg.
`timescale 1ns / 1ps

package tmwf_scoreboard_pkg;
  import tmwf_pkg::*;

  localparam int KEPT = (WINDOW_DEF > 2 * TRIM_DEF) ? WINDOW_DEF - 2 * TRIM_DEF : 0;
  localparam int REPORT_LIMIT = 10;
  localparam int SUM_MAX = (1 << TRIMMED_SUM_W) - 1;
  localparam int CODE_MAX = (1 << FILTERED_CODE_W) - 1;
  localparam int SAMPLE_MASK = (1 << SAMPLE_BITS_DEF) - 1;

  class filter_scoreboard;
    bit [SAMPLE_W-1:0] window [CHANNELS_DEF][WINDOW_DEF];
    int unsigned       head [CHANNELS_DEF];
    result_t           expected_q [$];
    int                mismatches;
    int                checked;

    function new();
      foreach (window[c, i]) window[c][i] = '0;
      foreach (head[c]) head[c] = 0;
      mismatches = 0;
      checked = 0;
    endfunction

    // Ranks the channel's window and sums all but the outer TRIM values on each side.
    function int unsigned trimmed_window_sum(int unsigned ch);
      int unsigned ranked [WINDOW_DEF];
      int unsigned v;
      int unsigned total;
      int          i;
      int          j;
      total = 0;
      for (i = 0; i < WINDOW_DEF; i++) begin
        v = 32'(window[ch][i]);
        j = i;
        while (j > 0 && ranked[j - 1] > v) begin
          ranked[j] = ranked[j - 1];
          j--;
        end
        ranked[j] = v;
      end
      for (i = TRIM_DEF; i + TRIM_DEF < WINDOW_DEF; i++) total += ranked[i];
      return total;
    endfunction

    function void note_item(item_t beat);
      result_t     exp;
      int unsigned ch;
      int unsigned total;
      int unsigned mean;
      ch = 32'(beat.channel);
      exp.out_channel = beat.channel;
      exp.trimmed_sum = '0;
      exp.filtered_code = '0;
      if (ch < CHANNELS_DEF) begin
        window[ch][head[ch]] = SAMPLE_W'(beat.sample & SAMPLE_MASK);
        head[ch] = (head[ch] == WINDOW_DEF - 1) ? 0 : head[ch] + 1;
        if (KEPT != 0) begin
          total = trimmed_window_sum(ch);
          mean = total / KEPT;
          exp.trimmed_sum = TRIMMED_SUM_W'((total > SUM_MAX) ? SUM_MAX : total);
          exp.filtered_code = FILTERED_CODE_W'((mean > CODE_MAX) ? CODE_MAX : mean);
        end
      end
      expected_q.push_back(exp);
    endfunction

    function void check_result(result_t got);
      result_t exp;
      checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("MISMATCH: result beat with nothing expected: ch=%0d sum=%0d code=%0d",
                   got.out_channel, got.trimmed_sum, got.filtered_code);
        return;
      end
      exp = expected_q.pop_front();
      if (got.out_channel !== exp.out_channel || got.trimmed_sum !== exp.trimmed_sum ||
          got.filtered_code !== exp.filtered_code) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("MISMATCH: expected ch=%0d sum=%0d code=%0d, got ch=%0d sum=%0d code=%0d",
                   exp.out_channel, exp.trimmed_sum, exp.filtered_code,
                   got.out_channel, got.trimmed_sum, got.filtered_code);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

>>> tb/trimmed_mean_window_filter_core_test.sv
// Top-level testbench for trimmed_mean_window_filter_core: drives tagged ADC sample
// beats with bursty valid and a patterned result stall, and checks every result beat.
// Depends on tmwf_pkg and the scoreboard in tmwf_scoreboard_pkg.
`timescale 1ns / 1ps

module trimmed_mean_window_filter_core_test;
  import tmwf_pkg::*;
  import tmwf_scoreboard_pkg::*;

  localparam int RANDOM_BEATS = 800;
  localparam int DRAIN_CYCLES = WINDOW_DEF + 20;
  localparam int BAD_CHANNEL = 7;
  localparam int CODE_TOP = (1 << SAMPLE_W) - 1;

  // Shapes of random sample values. Most beats stay near a per-channel level so
  // the trimming has real work to do; spikes, rails and spread values mix in.
  typedef enum int {
    SHAPE_NEAR,
    SHAPE_SPREAD,
    SHAPE_FLOOR,
    SHAPE_CEIL,
    SHAPE_SPIKE
  } sample_shape_t;

  // Receiver stall behavior, chosen afresh for each stretch of cycles.
  typedef enum int {
    STALL_NONE,
    STALL_RANDOM,
    STALL_LONG
  } stall_mode_t;

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_stall;
  item_t   item;
  logic    result_valid;
  logic    result_stall;
  result_t result;

  filter_scoreboard sb;
  int               beats_sent;
  int               out_of_range_beats;
  int unsigned      level [CHANNELS_DEF];

  trimmed_mean_window_filter_core u_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog. The slowest legal run needs under a millisecond of simulated time.
  initial begin
    #5ms;
    $display("Timeout: %0d beats sent, %0d results pending", beats_sent, sb.pending());
    $display("simulation failed");
    $finish;
  end

  // Present one beat at the falling edge and hold it until the block takes it.
  // The stall is sampled at the rising edge, before the block updates it.
  task automatic send_beat(item_t beat);
    @(negedge clk);
    item_valid <= 1'b1;
    item <= beat;
    do @(posedge clk); while (item_stall);
    sb.note_item(beat);
    beats_sent++;
    if (beat.channel >= CHANNELS_DEF) out_of_range_beats++;
  endtask

  // Drop valid for a number of cycles between bursts.
  task automatic hold_off(int cycles);
    @(negedge clk);
    item_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  function automatic item_t make_beat(int unsigned ch, int unsigned smp);
    item_t beat;
    beat.channel = CHANNEL_W'(ch);
    beat.sample = SAMPLE_W'(smp);
    return beat;
  endfunction

  // Builds one random beat. Roughly one beat in sixteen uses the unused channel code.
  function automatic item_t random_beat();
    int unsigned   ch;
    int unsigned   pick;
    int unsigned   smp;
    int            near;
    sample_shape_t shape;
    ch = ($urandom_range(0, 15) == 0) ? BAD_CHANNEL : $urandom_range(0, CHANNELS_DEF - 1);
    pick = $urandom_range(0, 9);
    if (pick < 5) shape = SHAPE_NEAR;
    else if (pick < 7) shape = SHAPE_SPREAD;
    else if (pick == 7) shape = SHAPE_FLOOR;
    else if (pick == 8) shape = SHAPE_CEIL;
    else shape = SHAPE_SPIKE;
    case (shape)
      SHAPE_NEAR: begin
        // Occasionally move the channel's level so the window walks over time.
        if (ch < CHANNELS_DEF && $urandom_range(0, 31) == 0)
          level[ch] = $urandom_range(0, CODE_TOP);
        near = (ch < CHANNELS_DEF) ? int'(level[ch]) : 2048;
        near = near + int'($urandom_range(0, 64)) - 32;
        if (near < 0) near = 0;
        if (near > CODE_TOP) near = CODE_TOP;
        smp = unsigned'(near);
      end
      SHAPE_SPREAD: smp = $urandom_range(0, CODE_TOP);
      SHAPE_FLOOR:  smp = 0;
      SHAPE_CEIL:   smp = CODE_TOP;
      default:      smp = $urandom_range(0, 1) ? $urandom_range(3800, CODE_TOP)
                                               : $urandom_range(0, 300);
    endcase
    return make_beat(ch, smp);
  endfunction

  // Result monitor: every accepted result beat goes to the scoreboard.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result);
  end

  // Receiver stall pattern: stretches of no stall, random stall, and long stalls.
  initial begin
    int          span;
    stall_mode_t mode;
    result_stall = 1'b0;
    forever begin
      mode = stall_mode_t'($urandom_range(0, 2));
      span = $urandom_range(5, 60);
      case (mode)
        STALL_NONE: begin
          @(negedge clk);
          result_stall <= 1'b0;
          repeat (span - 1) @(negedge clk);
        end
        STALL_RANDOM: begin
          repeat (span) begin
            @(negedge clk);
            result_stall <= ($urandom_range(0, 2) == 0);
          end
        end
        default: begin
          @(negedge clk);
          result_stall <= 1'b1;
          repeat ($urandom_range(1, 40)) @(negedge clk);
          result_stall <= 1'b0;
        end
      endcase
    end
  end

  initial begin
    int burst;
    int gap;
    int i;
    sb = new();
    beats_sent = 0;
    out_of_range_beats = 0;
    foreach (level[c]) level[c] = $urandom_range(0, CODE_TOP);
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. The unused channel code must leave all windows alone and
    // return zeros. Then every channel sees a full-scale sample into a window
    // of zeros, which the trimming removes entirely. Finally one channel is
    // filled with full-scale samples past the end of its ring, which drives
    // the trimmed sum and the mean to their largest values.
    send_beat(make_beat(BAD_CHANNEL, CODE_TOP));
    send_beat(make_beat(BAD_CHANNEL, 0));
    for (i = 0; i < CHANNELS_DEF; i++) send_beat(make_beat(i, CODE_TOP));
    hold_off(3);
    for (i = 0; i < WINDOW_DEF; i++) begin
      send_beat(make_beat(1, CODE_TOP));
      if (i % 5 == 4) hold_off(i);
    end

    // Random part, sent in bursts of random length with random gaps.
    i = 0;
    while (i < RANDOM_BEATS) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        if (i < RANDOM_BEATS) send_beat(random_beat());
        i++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) hold_off(gap);
    end
    hold_off(1);

    // Wait for the last results, then watch a little longer for stray beats.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d sample beats (%0d on the unused channel code), checked %0d results.",
             beats_sent, out_of_range_beats, sb.checked);
    $display("Mismatches: %0d, results still expected: %0d.", sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
